// ===== sv/tccw_pkg.sv =====
package tccw_pkg;

  // Fixed field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;

  // Action codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Control characters and printable range
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  // White on black space
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [3:0]  bg_color;
    logic [3:0]  fg_color;
    logic [10:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [LOC_W-1:0]  cursor_location;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic blank_step;
    logic copy_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       needs_scroll;
    logic       blank_last;
    logic       copy_last;
  } status_t;

endpackage

// ===== sv/tccw_ram.sv =====
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tccw_dp.sv =====
module tccw_dp
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  output status_t status_o,
  input  in_t     in_data_i,
  output out_t    out_data_o
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(CELLS + 1);
  localparam int COPY_N = CELLS - COLUMNS;
  localparam int LIN_W  = (AW > LOC_W) ? AW : LOC_W;

  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [CW-1:0]     cnt_q;
  logic [1:0]        action_q;
  logic              rd_ok_q;
  logic              scroll_q;
  out_t              out_q;

  logic [COL_W:0]    col_n;
  logic [ROW_W:0]    row_n;
  logic              put_wr;
  logic              put_scroll;
  logic [LIN_W-1:0]  lin;
  logic              rd_ok;
  logic [CW-1:0]     cnt_plus;
  logic [CW-1:0]     cnt_prev;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Decode a put against the current cursor
  always_comb begin
    col_n  = {1'b0, col_q};
    row_n  = {1'b0, row_q};
    put_wr = 1'b0;
    if (in_data_i.char_code == CH_BS && col_q != '0) begin
      col_n = col_n - 8'd1;
    end else if (in_data_i.char_code == CH_TAB) begin
      col_n = (col_n + 8'd8) & 8'hF8;
    end else if (in_data_i.char_code == CH_CR) begin
      col_n = '0;
    end else if (in_data_i.char_code == CH_LF) begin
      col_n = '0;
      row_n = row_n + 6'd1;
    end else if (in_data_i.char_code >= CH_PRINT_LO &&
                 in_data_i.char_code <= CH_PRINT_HI) begin
      put_wr = 1'b1;
      col_n  = col_n + 8'd1;
    end
    // Wrap past the last column
    if (col_n >= 8'(COLUMNS)) begin
      col_n = '0;
      row_n = row_n + 6'd1;
    end
    // Pin to the last row; the sweep does the scroll
    put_scroll = (row_n >= 6'(ROWS));
    if (put_scroll) begin
      row_n = 6'(ROWS - 1);
    end
  end

  assign lin      = LIN_W'(32'(row_q) * COLUMNS + 32'(col_q));
  assign rd_ok    = (32'(in_data_i.cell_index) < CELLS);
  assign cnt_plus = cnt_q + CW'(COLUMNS);
  assign cnt_prev = cnt_q - CW'(1);

  // Select the RAM access for this cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lin[AW-1:0];
    ram_wdata = {in_data_i.bg_color, in_data_i.fg_color, in_data_i.char_code};
    ram_re    = 1'b0;
    ram_raddr = AW'(in_data_i.cell_index);
    if (cmd_i.accept) begin
      ram_we = (in_data_i.action == ACT_PUT) && put_wr;
      ram_re = (in_data_i.action == ACT_READ) && rd_ok;
    end
    if (cmd_i.blank_step) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[AW-1:0];
      ram_wdata = BLANK_CELL;
    end
    if (cmd_i.copy_step) begin
      // Read one row ahead, write the registered data back in the following cycle
      if (cnt_q < CW'(COPY_N)) begin
        ram_re    = 1'b1;
        ram_raddr = cnt_plus[AW-1:0];
      end
      if (cnt_q != '0) begin
        ram_we    = 1'b1;
        ram_waddr = cnt_prev[AW-1:0];
        ram_wdata = (cnt_prev < CW'(COPY_N)) ? ram_rdata : BLANK_CELL;
      end
    end
  end

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Cursor and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        cnt_q <= '0;
        if (in_data_i.action == ACT_PUT) begin
          col_q <= col_n[COL_W-1:0];
          row_q <= row_n[ROW_W-1:0];
        end else if (in_data_i.action == ACT_CLEAR) begin
          col_q <= '0;
          row_q <= '0;
        end
      end else if (cmd_i.blank_step || cmd_i.copy_step) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Item details and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= in_data_i.action;
      rd_ok_q  <= rd_ok;
      scroll_q <= put_scroll;
    end
    if (cmd_i.out_load) begin
      out_q.cursor_location <= lin[LOC_W-1:0];
      out_q.cell_data       <= (action_q == ACT_READ && rd_ok_q) ? ram_rdata : '0;
      out_q.scrolled        <= (action_q == ACT_PUT) && scroll_q;
    end
  end

  assign status_o.action       = in_data_i.action;
  assign status_o.needs_scroll = put_scroll;
  assign status_o.blank_last   = (cnt_q == CW'(CELLS - 1));
  assign status_o.copy_last    = (cnt_q == CW'(CELLS));
  assign out_data_o            = out_q;

endmodule

// ===== sv/tccw_ctrl.sv =====
module tccw_ctrl
  import tccw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Commands per state
  always_comb begin
    cmd_o.accept     = in_valid_i && (state_q == ST_IDLE);
    cmd_o.blank_step = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    cmd_o.copy_step  = (state_q == ST_SCROLL);
    cmd_o.out_load   = (state_q == ST_FINISH) && out_free;
  end

  // Next state and result valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
    case (state_q)
      ST_INIT: begin
        if (status_i.blank_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_o.accept) begin
          case (status_i.action)
            ACT_PUT:   state_d = status_i.needs_scroll ? ST_SCROLL : ST_FINISH;
            ACT_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_FINISH;
          endcase
        end
      end
      ST_CLEAR: begin
        if (status_i.blank_last) state_d = ST_FINISH;
      end
      ST_SCROLL: begin
        if (status_i.copy_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/text_console_cell_writer.sv =====
// An item is accepted in the idle state and its result is registered from the finish state.
// A put, read or ignored item holds the input stalled until then; the output register frees it.
// Clear and a scrolling put add a sweep over all COLUMNS*ROWS cells: the single
// write port of the cell RAM sweeps every cell, one per cycle.
// Reset: cursor homes and the block blanks all COLUMNS*ROWS cells with stall high.
module text_console_cell_writer
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tccw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // Every accepted item stalls the input after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input taken again right after an item");

  // A clear always starts a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.action == ACT_CLEAR |=> ##1 in_stall_o && !out_valid_o ||
    in_stall_o)
    else $error("clear did not hold the input");

  // A scrolling result never carries cell data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.scrolled |-> out_data_o.cell_data == '0)
    else $error("scrolled result with cell data");

  // A result appears only after an item was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a pending item");

endmodule

// ===== sim/tb_text_console_cell_writer.sv =====
module tb_text_console_cell_writer;
  import tccw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOLS = 80;
  localparam int NROWS = 25;
  localparam int NCELLS = NCOLS * NROWS;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Generous: every item could take a full screen sweep plus stalls and gaps
  localparam int CYCLE_LIMIT = 15_000_000;
  // Idle stretch before the summary
  localparam int TAIL_CYCLES = 2100;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  text_console_cell_writer #(
    .COLUMNS(NCOLS),
    .ROWS   (NROWS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Screen image and cursor as the block should hold them
  logic [CELL_W-1:0] screen_model [NCELLS];
  int cur_col;
  int cur_row;

  out_t expected_reports [$];
  int errors;
  int items_sent;
  int reports_checked;
  int scrolls_seen;
  int clears_sent;
  int reads_sent;
  int reads_off_screen;
  int burst_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one item to the screen image and return the result it should give
  function automatic out_t console_step(input in_t item);
    out_t rep;
    int col;
    int row;
    logic [7:0] ch;
    rep = '0;
    col = cur_col;
    row = cur_row;
    ch = item.char_code;
    case (item.action)
      ACT_PUT: begin
        if (ch == CH_BS && col != 0) begin
          col--;
        end else if (ch == CH_TAB) begin
          col = (col + 8) & ~7;
        end else if (ch == CH_CR) begin
          col = 0;
        end else if (ch == CH_LF) begin
          col = 0;
          row++;
        end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
          screen_model[row * NCOLS + col] = {item.bg_color, item.fg_color, ch};
          col++;
        end
        // Wrap past the last column
        if (col >= NCOLS) begin
          col = 0;
          row++;
        end
        // Scroll up one line and blank the bottom row
        if (row >= NROWS) begin
          for (int i = 0; i < (NROWS - 1) * NCOLS; i++) begin
            screen_model[i] = screen_model[i + NCOLS];
          end
          for (int i = (NROWS - 1) * NCOLS; i < NCELLS; i++) begin
            screen_model[i] = BLANK_CELL;
          end
          row = NROWS - 1;
          rep.scrolled = 1'b1;
          scrolls_seen++;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) begin
          screen_model[i] = BLANK_CELL;
        end
        col = 0;
        row = 0;
        clears_sent++;
      end
      ACT_READ: begin
        reads_sent++;
        if (item.cell_index < NCELLS) begin
          rep.cell_data = screen_model[item.cell_index];
        end else begin
          reads_off_screen++;
        end
      end
      default: begin
      end
    endcase
    cur_col = col;
    cur_row = row;
    rep.cursor_location = LOC_W'(row * NCOLS + col);
    return rep;
  endfunction

  function automatic in_t make_item(input logic [1:0] action, input logic [7:0] ch,
                                    input logic [3:0] back, input logic [3:0] fore,
                                    input logic [10:0] index);
    in_t item;
    item.action = action;
    item.char_code = ch;
    item.bg_color = back;
    item.fg_color = fore;
    item.cell_index = index;
    return item;
  endfunction

  // Offer one item, hold it until taken, then maybe pause between bursts
  task automatic send_item(input in_t item);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_reports.push_back(console_step(item));
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0: gap = 0;
        1, 2: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(4, 12);
      endcase
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Stop sending and let every outstanding result arrive
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [3:0] rand_nibble();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
  endfunction

  // Byte that a put ignores: non-listed control or high half
  function automatic logic [7:0] rand_ignored();
    logic [7:0] ch;
    ch = CH_PRINT_LO;
    while ((ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) || ch == CH_BS || ch == CH_TAB ||
           ch == CH_LF || ch == CH_CR) begin
      ch = 8'($urandom_range(0, 255));
    end
    return ch;
  endfunction

  // Read address on or shortly behind the cursor
  function automatic logic [10:0] near_cursor();
    int idx;
    idx = cur_row * NCOLS + cur_col - $urandom_range(0, 160);
    if (idx < 0) idx = 0;
    return 11'(idx);
  endfunction

  // Blank screen after reset, reads past the end, unused action
  task automatic test_idle_screen();
    send_item(make_item(ACT_READ, 8'h00, 4'h0, 4'h0, 11'd0));
    send_item(make_item(ACT_READ, 8'h00, 4'h0, 4'h0, 11'(NCELLS - 1)));
    send_item(make_item(ACT_READ, 8'h00, 4'h0, 4'h0, 11'(NCELLS)));
    send_item(make_item(ACT_READ, 8'hFF, 4'hF, 4'hF, 11'h7FF));
    send_item(make_item(ACT_UNUSED, 8'h41, 4'hF, 4'hF, 11'h7FF));
  endtask

  // Printable range edges, color extremes, ignored bytes
  task automatic test_put_extremes();
    send_item(make_item(ACT_PUT, CH_PRINT_LO, 4'hF, 4'h0, 11'd0));
    send_item(make_item(ACT_PUT, CH_PRINT_HI, 4'h0, 4'hF, 11'd0));
    send_item(make_item(ACT_PUT, 8'h00, 4'hF, 4'hF, 11'd0));
    send_item(make_item(ACT_PUT, 8'h1F, 4'hF, 4'hF, 11'd0));
    send_item(make_item(ACT_PUT, 8'h80, 4'hF, 4'hF, 11'd0));
    send_item(make_item(ACT_PUT, 8'hFF, 4'hF, 4'hF, 11'd0));
    send_item(make_item(ACT_READ, 8'h00, 4'h0, 4'h0, 11'd0));
    send_item(make_item(ACT_READ, 8'h00, 4'h0, 4'h0, 11'd1));
  endtask

  // Backspace, backspace at column zero, tab, CR, LF, clear
  task automatic test_controls();
    send_item(make_item(ACT_PUT, CH_BS, 4'h0, 4'h0, 11'd0));
    send_item(make_item(ACT_PUT, CH_TAB, 4'h0, 4'h0, 11'd0));
    send_item(make_item(ACT_PUT, CH_CR, 4'h0, 4'h0, 11'd0));
    send_item(make_item(ACT_PUT, CH_BS, 4'h0, 4'h0, 11'd0));
    send_item(make_item(ACT_PUT, CH_LF, 4'h0, 4'h0, 11'd0));
    send_item(make_item(ACT_PUT, 8'h41, 4'h5, 4'hA, 11'd0));
    send_item(make_item(ACT_READ, 8'h00, 4'h0, 4'h0, 11'(NCOLS)));
    send_item(make_item(ACT_CLEAR, 8'h41, 4'hF, 4'hF, 11'h7FF));
    send_item(make_item(ACT_READ, 8'h00, 4'h0, 4'h0, 11'(NCOLS)));
  endtask

  // Short lines of text with edits, reads near the cursor, scrolling by LF
  task automatic test_text_lines(input int count);
    int done;
    int pick;
    logic ignored;
    in_t item;
    done = 0;
    while (done < count) begin
      item = make_item(ACT_PUT, rand_printable(), rand_nibble(), rand_nibble(),
                       11'($urandom_range(0, 2047)));
      ignored = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
      end else if (pick < 78) begin
        item.char_code = CH_LF;
      end else if (pick < 82) begin
        item.char_code = CH_CR;
      end else if (pick < 86) begin
        item.char_code = CH_TAB;
      end else if (pick < 90) begin
        item.char_code = CH_BS;
      end else if (pick < 97) begin
        item.action = ACT_READ;
        item.cell_index = near_cursor();
      end else begin
        item.char_code = rand_ignored();
        ignored = 1'b1;
      end
      send_item(item);
      if (!ignored) done++;
      // Hold off now and then until the block has caught up
      if ($urandom_range(0, 299) == 0) wait_idle();
    end
  endtask

  // Lines that often run past a row so that wrapping drives the scroll
  task automatic test_long_lines(input int count);
    int done;
    int run;
    in_t item;
    done = 0;
    while (done < count) begin
      run = $urandom_range(60, 200);
      for (int i = 0; i < run && done < count; i++) begin
        item = make_item(ACT_PUT, rand_printable(), rand_nibble(), rand_nibble(), 11'd0);
        case ($urandom_range(0, 19))
          0, 1: item.char_code = CH_TAB;
          2: begin
            item.action = ACT_READ;
            item.cell_index = near_cursor();
          end
          default: begin
          end
        endcase
        send_item(item);
        done++;
      end
      item = make_item(ACT_PUT, ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF,
                       rand_nibble(), rand_nibble(), 11'd0);
      send_item(item);
      done++;
    end
  endtask

  // Unshaped items over every field value, with the odd clear
  task automatic test_random_noise(input int count);
    int done;
    int pick;
    in_t item;
    done = 0;
    while (done < count) begin
      item = make_item(ACT_PUT, 8'($urandom_range(0, 255)), rand_nibble(), rand_nibble(),
                       11'($urandom_range(0, 2047)));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        item.action = ACT_READ;
      end else if (pick < 33) begin
        item.action = ACT_UNUSED;
      end else if (pick < 36) begin
        item.action = ACT_CLEAR;
      end
      send_item(item);
      done++;
    end
  endtask

  // Receiver stall pattern: quiet, random and periodic stretches
  initial begin
    int mode;
    int left;
    out_stall_i <= 1'b0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 160);
      end
      left--;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 1) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ((left % 8) < 5);
      endcase
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, out_data_o);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (out_data_o.cursor_location !== want.cursor_location) begin
          $display("%0t: cursor_location expected %0d actual %0d", $time,
                   want.cursor_location, out_data_o.cursor_location);
          errors++;
        end
        if (out_data_o.cell_data !== want.cell_data) begin
          $display("%0t: cell_data expected %h actual %h", $time,
                   want.cell_data, out_data_o.cell_data);
          errors++;
        end
        if (out_data_o.scrolled !== want.scrolled) begin
          $display("%0t: scrolled expected %b actual %b", $time,
                   want.scrolled, out_data_o.scrolled);
          errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
             CYCLE_LIMIT, expected_reports.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    errors = 0;
    items_sent = 0;
    reports_checked = 0;
    scrolls_seen = 0;
    clears_sent = 0;
    reads_sent = 0;
    reads_off_screen = 0;
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < NCELLS; i++) begin
      screen_model[i] = BLANK_CELL;
    end
    cur_col = 0;
    cur_row = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_screen();
    test_put_extremes();
    test_controls();
    wait_idle();
    test_text_lines(850);
    wait_idle();
    test_long_lines(250);
    test_random_noise(380);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results: %0d scrolls, %0d clears,", items_sent,
             reports_checked, scrolls_seen, clears_sent);
    $display("%0d reads (%0d past the screen end).", reads_sent, reads_off_screen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
